// ===== rtl/wcs_pkg.sv =====
// Shared types, constants and helpers for the windowed chirp synthesizer.
// No dependencies; every other file of the block but the checker imports this package.
`default_nettype none

package wcs_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 8;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_STEP   = 8'd0,
        REG_CHIRP_RATE  = 8'd1,
        REG_START_PHASE = 8'd2,
        REG_AMPLITUDE   = 8'd3
    } t_reg_idx;

    // Field and datapath widths fixed by the block's format.
    localparam int CFG_DATA_W  = 48;
    localparam int FREQ_W      = 48;
    localparam int PHASE_IN_W  = 16;
    localparam int AMP_W       = 16;
    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 49;
    localparam int CORDIC_W    = 33;
    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_CNT_W = $clog2(CORDIC_STAGES);
    localparam int WA_W        = 33;
    localparam int PROD_W      = 49;

    // CORDIC start value: the inverse of the rotation gain in Q2.30.
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

    // Queue between the front and back halves.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Queue status seen by both halves.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Rotation angle of each CORDIC stage in units of 2^-32 turn.
    function automatic logic [29:0] atan_turn(input logic [STAGE_CNT_W-1:0] i);
        logic [29:0] a;
        unique case (i)
            4'd0:  a = 30'h20000000;
            4'd1:  a = 30'h12E4051E;
            4'd2:  a = 30'h09FB385B;
            4'd3:  a = 30'h051111D4;
            4'd4:  a = 30'h028B0D43;
            4'd5:  a = 30'h0145D7E1;
            4'd6:  a = 30'h00A2F61E;
            4'd7:  a = 30'h00517C55;
            4'd8:  a = 30'h0028BE53;
            4'd9:  a = 30'h00145F2F;
            4'd10: a = 30'h000A2F98;
            4'd11: a = 30'h000517CC;
            4'd12: a = 30'h00028BE6;
            4'd13: a = 30'h000145F3;
            4'd14: a = 30'h0000A2FA;
            4'd15: a = 30'h0000517D;
            default: a = 30'h0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wcs_front.sv =====
// Front half: accepts window beats, runs the phase accumulator and pushes
// the quantized phase plus window into the queue. Depends on wcs_pkg.
`default_nettype none

module wcs_front import wcs_pkg::*; #(
    parameter int COS_TABLE_BITS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output      logic                          o_ready,
    input  wire logic signed [SAMPLE_W-1:0]    i_window,
    input  wire logic                          i_restart,
    input  wire logic [FREQ_W-1:0]             i_freq_step,
    input  wire logic [FREQ_W-1:0]             i_chirp_rate,
    input  wire logic [PHASE_IN_W-1:0]         i_start_phase,
    input  wire t_q_stat                       i_q_stat,
    output      logic                          o_push,
    output      logic [COS_TABLE_BITS+2+SAMPLE_W-1:0] o_push_data
);

    localparam int PH_W = COS_TABLE_BITS + 2;

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [ACC_W-1:0] r_inc, n_inc;
    logic [ACC_W-1:0] chirp49;
    logic [ACC_W-1:0] acc_use;
    logic [ACC_W-1:0] inc_use;
    logic             accept;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign chirp49 = {i_chirp_rate[FREQ_W-1], i_chirp_rate};

    // A restart beat reloads phase and step before the sample uses them.
    always_comb begin
        if (i_restart) begin
            acc_use = {i_start_phase, {(ACC_W-PHASE_IN_W){1'b0}}};
            inc_use = {i_freq_step, 1'b0} + chirp49;
        end else begin
            acc_use = r_acc;
            inc_use = r_inc;
        end
        n_acc = r_acc;
        n_inc = r_inc;
        if (accept) begin
            n_acc = acc_use + inc_use;
            n_inc = inc_use + {chirp49[ACC_W-2:0], 1'b0};
        end
    end

    // The top table bits of the phase go to the cosine unit.
    assign o_push      = accept;
    assign o_push_data = {i_window, acc_use[ACC_W-1 -: PH_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_inc <= '0;
        end else begin
            r_acc <= n_acc;
            r_inc <= n_inc;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wcs_queue.sv =====
// Two-entry queue that decouples the phase front end from the cosine back end.
// Depends on wcs_pkg for its depth and status type.
`default_nettype none

module wcs_queue import wcs_pkg::*; #(
    parameter int DATA_W = 28
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    input  wire logic              i_pop,
    output      logic [DATA_W-1:0] o_data,
    output      t_q_stat           o_stat
);

    logic [DATA_W-1:0]  r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    // Pointer and occupancy bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wcs_back.sv =====
// Back half: iterative CORDIC cosine, window and amplitude scaling, rounding
// and saturation into a registered output beat. Depends on wcs_pkg.
`default_nettype none

module wcs_back import wcs_pkg::*; #(
    parameter int COS_TABLE_BITS = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_q_stat                     i_q_stat,
    input  wire logic [COS_TABLE_BITS+2+SAMPLE_W-1:0] i_q_data,
    output      logic                        o_pop,
    input  wire logic [AMP_W-1:0]            i_amplitude,
    output      logic                        o_valid,
    input  wire logic                        i_ready,
    output      logic signed [SAMPLE_W-1:0]  o_wave
);

    localparam int B = COS_TABLE_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROT  = 5'b00010,
        S_MUL  = 5'b00100,
        S_PROD = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [STAGE_CNT_W-1:0]       r_cnt, n_cnt;
    logic signed [CORDIC_W-1:0]   r_x, n_x;
    logic signed [CORDIC_W-1:0]   r_y, n_y;
    logic signed [CORDIC_W-1:0]   r_z, n_z;
    logic [1:0]                   r_quad, n_quad;
    logic signed [SAMPLE_W-1:0]   r_win, n_win;
    logic signed [SAMPLE_W-1:0]   r_cos, n_cos;
    logic signed [WA_W-1:0]       r_wa, n_wa;
    logic signed [PROD_W-1:0]     r_prod, n_prod;
    logic                         r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0]   r_out_wave, n_out_wave;

    logic signed [CORDIC_W-1:0]   dx;
    logic signed [CORDIC_W-1:0]   dy;
    logic signed [CORDIC_W-1:0]   atan_z;
    logic signed [CORDIC_W-1:0]   c_sel;
    logic signed [CORDIC_W-1:0]   c_shift;
    logic signed [PROD_W-1:0]     s_shift;
    logic [B-1:0]                 q_angle;

    assign o_valid = r_out_valid;
    assign o_wave  = r_out_wave;
    assign o_pop   = (r_state == S_IDLE) && !i_q_stat.empty;
    assign q_angle = i_q_data[B-1:0];

    // One CORDIC micro-rotation per cycle; the shifts round toward minus infinity.
    assign dx     = r_y >>> r_cnt;
    assign dy     = r_x >>> r_cnt;
    assign atan_z = $signed({3'b000, atan_turn(r_cnt)});

    // Quadrant folding and Q2.30 to Q1.15 rounding.
    always_comb begin
        unique case (r_quad)
            2'd0:    c_sel = r_x;
            2'd1:    c_sel = -r_y;
            2'd2:    c_sel = -r_x;
            default: c_sel = r_y;
        endcase
    end
    assign c_shift = (c_sel + 33'sd16384) >>> 15;
    assign s_shift = (r_prod + 49'sd1073741824) >>> 31;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_quad      = r_quad;
        n_win       = r_win;
        n_cos       = r_cos;
        n_wa        = r_wa;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out_wave  = r_out_wave;

        // The downstream side takes the waiting beat.
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_x     = CORDIC_X0;
                    n_y     = '0;
                    n_z     = $signed(CORDIC_W'(q_angle) << (30 - B));
                    n_quad  = i_q_data[B+1:B];
                    n_win   = $signed(i_q_data[B+2 +: SAMPLE_W]);
                    n_cnt   = '0;
                    n_state = S_ROT;
                end
            end
            S_ROT: begin
                if (!r_z[CORDIC_W-1]) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - atan_z;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + atan_z;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STAGE_CNT_W'(CORDIC_STAGES-1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Clamp the cosine to the symmetric Q1.15 range.
                if (c_shift > 33'sd32767) begin
                    n_cos = 16'sd32767;
                end else if (c_shift < -33'sd32767) begin
                    n_cos = -16'sd32767;
                end else begin
                    n_cos = c_shift[SAMPLE_W-1:0];
                end
                n_wa    = r_win * $signed({1'b0, i_amplitude});
                n_state = S_PROD;
            end
            S_PROD: begin
                n_prod  = r_wa * r_cos;
                n_state = S_DONE;
            end
            S_DONE: begin
                // Load the output register once it is free or being emptied.
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    if (s_shift > 49'sd32767) begin
                        n_out_wave = 16'sd32767;
                    end else if (s_shift < -49'sd32768) begin
                        n_out_wave = -16'sd32768;
                    end else begin
                        n_out_wave = s_shift[SAMPLE_W-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_z        <= n_z;
        r_quad     <= n_quad;
        r_win      <= n_win;
        r_cos      <= n_cos;
        r_wa       <= n_wa;
        r_prod     <= n_prod;
        r_out_wave <= n_out_wave;
    end

endmodule

`default_nettype wire

// ===== rtl/windowed_chirp_synth.sv =====
// Top level of the windowed linear-chirp synthesizer: configuration registers
// and the front, queue and back halves. Depends on wcs_pkg and its submodules.
`default_nettype none

// Each accepted beat carries one window sample and a restart flag and yields
// one output beat, window * amplitude * cos(phase), rounded and saturated to
// Q1.15. The phase accumulator in the front half accepts a beat whenever the
// two-entry queue has room, so short bursts enter at one beat per cycle. The
// back half computes one sample at a time: it loads from the queue, runs 16
// rotations of the shared CORDIC unit, does the two multiplies, then loads
// the output register, waiting while the output is stalled; this CORDIC loop
// sets the sustained rate. Configuration writes are always taken (ready is
// high); start_phase and freq_step take effect at the next restart beat,
// chirp_rate at once, amplitude on samples not yet scaled. Write configuration
// only while the block is idle. Indexes past the last register are ignored.
module windowed_chirp_synth import wcs_pkg::*; #(
    parameter int COS_TABLE_BITS = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream.
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    input  wire logic [15:0]            s_axis_tdata,   // [15:0] window_sample
    input  wire logic                   s_axis_tuser,   // [0] restart
    // Output stream.
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output      logic [15:0]            m_axis_tdata,   // [15:0] wave_sample
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output      logic                   o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int PH_W   = COS_TABLE_BITS + 2;
    localparam int ITEM_W = PH_W + SAMPLE_W;

    logic [FREQ_W-1:0]     r_freq_step;
    logic [FREQ_W-1:0]     r_chirp_rate;
    logic [PHASE_IN_W-1:0] r_start_phase;
    logic [AMP_W-1:0]      r_amplitude;

    t_q_stat               q_stat;
    logic                  q_push;
    logic [ITEM_W-1:0]     q_push_data;
    logic                  q_pop;
    logic [ITEM_W-1:0]     q_pop_data;
    logic signed [SAMPLE_W-1:0] wave;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = wave;

    // Register writes; unknown indexes fall through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_step   <= '0;
            r_chirp_rate  <= '0;
            r_start_phase <= '0;
            r_amplitude   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FREQ_STEP:   r_freq_step   <= i_cfg_data[FREQ_W-1:0];
                REG_CHIRP_RATE:  r_chirp_rate  <= i_cfg_data[FREQ_W-1:0];
                REG_START_PHASE: r_start_phase <= i_cfg_data[PHASE_IN_W-1:0];
                REG_AMPLITUDE:   r_amplitude   <= i_cfg_data[AMP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wcs_front #(
        .COS_TABLE_BITS(COS_TABLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_window     ($signed(s_axis_tdata)),
        .i_restart    (s_axis_tuser),
        .i_freq_step  (r_freq_step),
        .i_chirp_rate (r_chirp_rate),
        .i_start_phase(r_start_phase),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_push_data  (q_push_data)
    );

    wcs_queue #(
        .DATA_W(ITEM_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_push_data),
        .i_pop  (q_pop),
        .o_data (q_pop_data),
        .o_stat (q_stat)
    );

    wcs_back #(
        .COS_TABLE_BITS(COS_TABLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_q_data   (q_pop_data),
        .o_pop      (q_pop),
        .i_amplitude(r_amplitude),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_wave     (wave)
    );

endmodule

`default_nettype wire

// ===== rtl/wcs_checker.sv =====
// Port-level checks for the windowed chirp synthesizer, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module wcs_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_valid,
    input  wire logic        i_s_ready,
    input  wire logic        i_m_valid,
    input  wire logic        i_m_ready,
    input  wire logic [15:0] i_m_data
);

    // Beats accepted but not yet delivered; the block holds at most four.
    logic [2:0] r_pending, n_pending;

    always_comb begin
        n_pending = r_pending;
        if ((i_s_valid && i_s_ready) && !(i_m_valid && i_m_ready)) begin
            n_pending = r_pending + 1'b1;
        end else if (!(i_s_valid && i_s_ready) && (i_m_valid && i_m_ready)) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid && !i_m_ready |=> i_m_valid)
        else $error("output valid dropped before its beat was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid && !i_m_ready |=> $stable(i_m_data))
        else $error("output data changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_valid)
        else $error("output valid after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_valid |-> r_pending != 3'd0)
        else $error("output beat without a pending input beat");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd4)
        else $error("more beats in flight than the block can hold");

endmodule

bind windowed_chirp_synth wcs_checker u_wcs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_s_valid(s_axis_tvalid),
    .i_s_ready(s_axis_tready),
    .i_m_valid(m_axis_tvalid),
    .i_m_ready(m_axis_tready),
    .i_m_data (m_axis_tdata)
);

`default_nettype wire
